// ----- src/bfa_pkg.sv -----
// ----------------------------------------------------------------------------
// bfa_pkg: shared types and constants for the best-fit block allocator
// Table geometry, queue item layout and back-end state encoding.
// ----------------------------------------------------------------------------
package bfa_pkg;

   localparam int TABLE_ENTRIES = 16; // table entries
   localparam int SIZE_BITS   = 16;   // stored size width
   localparam int QUEUE_DEPTH = 2;    // front-to-back item queue

   // fixed field widths of the channels
   localparam int SLOT_W  = 4;
   localparam int SIZEIN_W = 16;
   localparam int OWNER_W = 16;
   localparam int CHOSEN_W = 4;
   localparam int CSR_W   = 5;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int QP_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [OWNER_W-1:0] OWNER_MAX = {OWNER_W{1'b1}};

   // request kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_ALLOC = 1'b1;

   typedef struct packed {
      logic                is_alloc;
      logic [SLOT_W-1:0]   slot;
      logic [SIZE_BITS-1:0] size;
   } item_type;

   // front -> back
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

endpackage

// ----- src/bfa_front.sv -----
// ----------------------------------------------------------------------------
// bfa_front: request intake
// Decodes incoming beats into queue items and buffers them for the back end.
// ----------------------------------------------------------------------------
module bfa_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic                    req_type,
   input  logic [bfa_pkg::SLOT_W-1:0]   req_block_slot,
   input  logic [bfa_pkg::SIZEIN_W-1:0] req_size_value,
   output bfa_pkg::queue_head_type head,
   input  logic                    head_pop
);
   import bfa_pkg::*;

   item_type            slot_ff [QUEUE_DEPTH];
   logic [QP_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0]     count_ff, count_in;
   logic                do_push, do_pop;
   item_type            new_item;

   assign full    = (count_ff == QC_W'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = head_pop && (count_ff != '0);

   always_comb begin
      new_item.is_alloc = (req_type == KIND_ALLOC);
      new_item.slot     = req_block_slot;
      new_item.size     = SIZE_BITS'(req_size_value);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

endmodule

// ----- src/bfa_back.sv -----
// ----------------------------------------------------------------------------
// bfa_back: table engine
// Applies loads, runs the best-fit scan one entry per cycle and holds the
// result register.
// ----------------------------------------------------------------------------
module bfa_back (
   input  logic                    clock,
   input  logic                    reset,
   input  bfa_pkg::queue_head_type head,
   output logic                    head_pop,
   input  logic                    csr_wr_en,
   input  logic [bfa_pkg::CSR_W-1:0] csr_wr_data,
   output logic                    empty,
   input  logic                    pop,
   output logic                    rsp_granted,
   output logic [bfa_pkg::CHOSEN_W-1:0] rsp_chosen_block,
   output logic [bfa_pkg::OWNER_W-1:0]  rsp_owner_number,
   output logic                    rsp_stopped
);
   import bfa_pkg::*;

   // size table; owners are never read back, so only busy marks are kept
   logic [SIZE_BITS-1:0] size_mem [TABLE_ENTRIES];

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]       limit_ff, limit_in;
   logic [SIZE_BITS-1:0]   want_ff, want_in;
   logic [TABLE_ENTRIES-1:0] busy_ff, busy_in;
   logic [OWNER_W-1:0]     cnt_ff, cnt_in;
   logic                   halted_ff, halted_in;
   logic [CSR_W-1:0]       in_use_ff;

   logic                   rd_en;
   logic                   rd_vld_ff;
   logic [SIZE_BITS-1:0]   rd_data_ff;
   logic [IDX_W-1:0]       rd_idx_ff;
   logic                   rd_busy_ff;

   logic                   best_found_ff, best_found_in;
   logic [IDX_W-1:0]       best_idx_ff, best_idx_in;
   logic [SIZE_BITS-1:0]   best_size_ff, best_size_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_granted_ff, rsp_granted_in;
   logic [CHOSEN_W-1:0]    rsp_chosen_ff, rsp_chosen_in;
   logic [OWNER_W-1:0]     rsp_owner_ff, rsp_owner_in;
   logic                   rsp_stopped_ff, rsp_stopped_in;

   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   logic                   slot_ok;
   logic [CNT_W-1:0]       limit_now;
   logic                   scan_last;

   assign slot_ok   = (32'(head.item.slot) < 32'(TABLE_ENTRIES));
   assign limit_now = (32'(in_use_ff) > 32'(TABLE_ENTRIES)) ? CNT_W'(TABLE_ENTRIES)
                                                            : CNT_W'(in_use_ff);
   assign scan_last = ((CNT_W'(scan_idx_ff) + 1'b1) == limit_ff);
   assign mem_waddr = IDX_W'(head.item.slot);

   always_comb begin
      state_in       = state_ff;
      scan_idx_in    = scan_idx_ff;
      limit_in       = limit_ff;
      want_in        = want_ff;
      busy_in        = busy_ff;
      cnt_in         = cnt_ff;
      halted_in      = halted_ff;
      best_found_in  = best_found_ff;
      best_idx_in    = best_idx_ff;
      best_size_in   = best_size_ff;
      rsp_valid_in   = rsp_valid_ff && !pop;
      rsp_granted_in = rsp_granted_ff;
      rsp_chosen_in  = rsp_chosen_ff;
      rsp_owner_in   = rsp_owner_ff;
      rsp_stopped_in = rsp_stopped_ff;
      head_pop       = 1'b0;
      mem_we         = 1'b0;
      rd_en          = 1'b0;

      // compare stage, one table entry per cycle
      if (rd_vld_ff && !rd_busy_ff && (rd_data_ff >= want_ff) &&
          (!best_found_ff || (rd_data_ff < best_size_ff))) begin
         best_found_in = 1'b1;
         best_idx_in   = rd_idx_ff;
         best_size_in  = rd_data_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               if (!head.item.is_alloc) begin
                  head_pop  = 1'b1;
                  halted_in = 1'b0;
                  if (slot_ok) begin
                     mem_we             = 1'b1;
                     busy_in[mem_waddr] = 1'b0;
                  end
               end else if (!rsp_valid_ff) begin
                  head_pop = 1'b1;
                  if (halted_ff || (limit_now == '0)) begin
                     // refused, or nothing to search
                     halted_in      = 1'b1;
                     rsp_valid_in   = 1'b1;
                     rsp_granted_in = 1'b0;
                     rsp_chosen_in  = '0;
                     rsp_owner_in   = '0;
                     rsp_stopped_in = 1'b1;
                  end else begin
                     want_in       = head.item.size;
                     limit_in      = limit_now;
                     scan_idx_in   = '0;
                     best_found_in = 1'b0;
                     state_in      = ST_ISSUE;
                  end
               end
            end
         end
         ST_ISSUE: begin
            rd_en = 1'b1;
            if (scan_last) begin
               state_in = ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            if (best_found_ff) begin
               busy_in[best_idx_ff] = 1'b1;
               rsp_granted_in = 1'b1;
               rsp_chosen_in  = CHOSEN_W'(best_idx_ff);
               rsp_owner_in   = cnt_ff;
               rsp_stopped_in = 1'b0;
               if (cnt_ff != OWNER_MAX) begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end else begin
               halted_in      = 1'b1;
               rsp_granted_in = 1'b0;
               rsp_chosen_in  = '0;
               rsp_owner_in   = '0;
               rsp_stopped_in = 1'b1;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         busy_ff       <= '0;
         cnt_ff        <= '0;
         halted_ff     <= 1'b0;
         in_use_ff     <= '0;
         rd_vld_ff     <= 1'b0;
         best_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         busy_ff       <= busy_in;
         cnt_ff        <= cnt_in;
         halted_ff     <= halted_in;
         rd_vld_ff     <= rd_en;
         best_found_ff <= best_found_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            in_use_ff <= csr_wr_data;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      scan_idx_ff    <= scan_idx_in;
      limit_ff       <= limit_in;
      want_ff        <= want_in;
      best_idx_ff    <= best_idx_in;
      best_size_ff   <= best_size_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_chosen_ff  <= rsp_chosen_in;
      rsp_owner_ff   <= rsp_owner_in;
      rsp_stopped_ff <= rsp_stopped_in;
   end

   // size table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         size_mem[mem_waddr] <= head.item.size;
      end
      if (rd_en) begin
         rd_data_ff <= size_mem[scan_idx_ff];
         rd_idx_ff  <= scan_idx_ff;
         rd_busy_ff <= busy_ff[scan_idx_ff];
      end
   end

   assign empty            = !rsp_valid_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_chosen_block = rsp_chosen_ff;
   assign rsp_owner_number = rsp_owner_ff;
   assign rsp_stopped      = rsp_stopped_ff;

   // a scan only starts with the result register free
   a_scan_rsp_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) |-> !rsp_valid_ff)
      else $error("scan running while a result is pending");

   a_done_returns: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> (state_ff == ST_IDLE) && rsp_valid_ff)
      else $error("scan end did not post a result");

   a_grant_not_stopped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_granted_ff) |-> !rsp_stopped_ff)
      else $error("grant reported together with stop");

   a_refuse_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_granted_ff) |->
         (rsp_chosen_ff == '0) && (rsp_owner_ff == '0) && rsp_stopped_ff)
      else $error("refusal carries stale fields");

   a_cnt_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (cnt_ff >= $past(cnt_ff)))
      else $error("request counter went backwards");

endmodule

// ----- src/best_fit_block_allocator_core.sv -----
// ----------------------------------------------------------------------------
// best_fit_block_allocator_core: best-fit block allocator, top level
// Queue-style request and response channels around a scan engine.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_* and raise push; the beat is taken on a
//   clock edge with push high and full low. req_type 0 loads a block size
//   into req_block_slot (and frees it), 1 asks for req_size_value.
//   Response channel: while empty is low the oldest result sits on rsp_*;
//   it is consumed on an edge with pop high. Loads produce no response.
//   CSR: csr_wr_en/csr_wr_data set blocks_in_use; write only when idle.
// Sequence:
//   A beat is registered in the intake queue before it reaches the head.
//   A load retires in ST_IDLE once at the queue head. An allocation at the
//   head takes ST_IDLE to start, ST_ISSUE for one table read per entry
//   through the single size-table read port, ST_DRAIN for the last compare
//   and ST_DONE to write back and post the result. A refused request
//   (stopped, or zero entries in use) is answered from ST_IDLE without a scan.
// Stall: a pending response holds off the next allocation; loads ahead of it in
//   the queue are still applied and up to two requests are still queued meanwhile.
// Reset: clears busy marks, request counter, stop flag, blocks_in_use, the
//   intake queue and response valid flag. Size entries are undefined until loaded.
// ----------------------------------------------------------------------------
module best_fit_block_allocator_core (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          push,
   output logic                          full,
   input  logic                          req_type,
   input  logic [bfa_pkg::SLOT_W-1:0]    req_block_slot,
   input  logic [bfa_pkg::SIZEIN_W-1:0]  req_size_value,
   // response channel
   output logic                          empty,
   input  logic                          pop,
   output logic                          rsp_granted,
   output logic [bfa_pkg::CHOSEN_W-1:0]  rsp_chosen_block,
   output logic [bfa_pkg::OWNER_W-1:0]   rsp_owner_number,
   output logic                          rsp_stopped,
   // configuration
   input  logic                          csr_wr_en,
   input  logic [bfa_pkg::CSR_W-1:0]     csr_wr_data
);
   import bfa_pkg::*;

   queue_head_type head;
   logic           head_pop;

   // intake queue decouples the request side from the scan engine
   bfa_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_type       (req_type),
      .req_block_slot (req_block_slot),
      .req_size_value (req_size_value),
      .head           (head),
      .head_pop       (head_pop)
   );

   // table, scan and response register
   bfa_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .head_pop         (head_pop),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .empty            (empty),
      .pop              (pop),
      .rsp_granted      (rsp_granted),
      .rsp_chosen_block (rsp_chosen_block),
      .rsp_owner_number (rsp_owner_number),
      .rsp_stopped      (rsp_stopped)
   );

endmodule
